// File: rtl/ffca_pkg.sv
// package for the first-fit coalescing allocator
// shared types, status codes and constants; no dependencies
package ffca_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [31:0] payload_address;
        logic [31:0] header_word;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
        logic [31:0] block_bytes;
    } rsp_t;

    // one segment as handed between cells
    typedef struct packed {
        logic        valid;
        logic [31:0] start;
        logic [31:0] length;
    } seg_t;

    // per-cycle command given to each cell
    typedef enum logic [2:0] {
        CC_HOLD  = 3'b001,
        CC_LEFT  = 3'b010,
        CC_RIGHT = 3'b100
    } cell_cmd_t;

endpackage

// File: rtl/ffca_cell.sv
// one free-table cell: holds a segment, shifts left or right with its neighbors
// and can be overwritten at its own index; uses ffca_pkg
module ffca_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ffca_pkg::cell_cmd_t cmd,
    input  ffca_pkg::seg_t      from_left,
    input  ffca_pkg::seg_t      from_right,
    input  logic                wr,
    input  ffca_pkg::seg_t      wr_seg,
    output ffca_pkg::seg_t      seg
);

    logic           valid_reg;
    logic [31:0]    start_reg;
    logic [31:0]    length_reg;
    ffca_pkg::seg_t seg_cur;
    ffca_pkg::seg_t seg_next;

    assign seg_cur = '{valid: valid_reg, start: start_reg, length: length_reg};

    always_comb
    begin
        seg_next = seg_cur;
        if (wr)
        begin
            seg_next = wr_seg;
        end
        else
        begin
            unique case (cmd)
                ffca_pkg::CC_LEFT:  seg_next = from_right;
                ffca_pkg::CC_RIGHT: seg_next = from_left;
                default:            seg_next = seg_cur;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= seg_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= seg_next.start;
        length_reg <= seg_next.length;
    end

    assign seg = seg_cur;

endmodule

// File: rtl/first_fit_coalescing_allocator_core.sv
// top level of the first-fit coalescing allocator
// sequencer, heap mark and a row of ffca_cell; uses ffca_pkg
//
// One request at a time: busy rises the cycle after start and the single
// result appears with done high for one cycle. The free table is a row of
// cells scanned one entry per cycle by the sequencer, then an insert or
// removal shifts the cells from the insert or removal point onward in the
// S_SHIFT state. The result cannot be stalled.
module first_fit_coalescing_allocator_core #(
    parameter int unsigned FREE_ENTRIES = 16,
    parameter int unsigned GRANULE      = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  ffca_pkg::req_t                        req,
    output logic                                  done,
    output ffca_pkg::rsp_t                        rsp,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [31:0]                           cfg_data
);

    localparam int unsigned IW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(FREE_ENTRIES + 1);
    localparam logic [31:0] GR   = 32'(GRANULE);
    localparam logic [31:0] GM   = 32'(GRANULE - 1);
    localparam logic [CW-1:0] FULL = CW'(FREE_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PREP   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_ACT    = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] limit_reg, mark_reg, mark_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic op_reg, op_next;
    logic [31:0] blk_reg, blk_next;     // block size or released segment start
    logic [31:0] len_reg, len_next;     // released length
    logic [2:0] st_reg, st_next;
    logic [31:0] ga_reg, ga_next, bb_reg, bb_next;
    logic done_reg, done_next;
    ffca_pkg::cell_cmd_t shift_reg, shift_next;
    logic [IW-1:0] pivot_reg, pivot_next;
    logic [CW-1:0] cnt_after_reg, cnt_after_next;

    ffca_pkg::seg_t segs [FREE_ENTRIES];
    ffca_pkg::seg_t lefts [FREE_ENTRIES];
    ffca_pkg::seg_t rights [FREE_ENTRIES];
    ffca_pkg::cell_cmd_t cmds [FREE_ENTRIES];
    logic wrs [FREE_ENTRIES];
    logic [IW-1:0] wr_idx;
    logic wr_en;
    ffca_pkg::seg_t wr_seg;

    ffca_pkg::seg_t cur, prv;
    logic [IW-1:0] ci, pi;
    logic [32:0] aligned33, blk33, inc33;
    logic [31:0] pad, diff, newlen;
    logic an, ap;

    assign ci = idx_reg[IW-1:0];
    assign pi = ci - IW'(1);
    assign cur = segs[ci];
    assign prv = segs[pi];

    genvar g;
    generate
        for (g = 0; g < FREE_ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_l
                assign lefts[g] = '0;
            end
            else
            begin : g_l
                assign lefts[g] = segs[g-1];
            end
            if (g == FREE_ENTRIES - 1)
            begin : g_r
                assign rights[g] = '0;
            end
            else
            begin : g_r
                assign rights[g] = segs[g+1];
            end
            assign wrs[g] = wr_en && (wr_idx == IW'(g));
            assign cmds[g] = (shift_reg == ffca_pkg::CC_LEFT && state_reg == S_SHIFT
                              && IW'(g) >= pivot_reg) ? ffca_pkg::CC_LEFT :
                             (shift_reg == ffca_pkg::CC_RIGHT && state_reg == S_SHIFT
                              && IW'(g) > pivot_reg) ? ffca_pkg::CC_RIGHT :
                             ffca_pkg::CC_HOLD;
            ffca_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmds[g]),
                .from_left (lefts[g]),
                .from_right(rights[g]),
                .wr        (wrs[g]),
                .wr_seg    (wr_seg),
                .seg       (segs[g])
            );
        end
    endgenerate

    always_comb
    begin
        aligned33 = ({1'b0, req.request_bytes} + {1'b0, GM}) & ~{1'b0, GM};
        blk33 = aligned33 + {1'b0, GR};
        pad = (32'd0 - mark_reg) & GM;
        inc33 = {1'b0, blk_reg} + {1'b0, pad};
        diff = limit_reg - mark_reg;
        newlen = cur.length - blk_reg;
        // adjacency against neighbors of the insert point
        an = (idx_reg < count_reg) && (blk_reg + len_reg == cur.start);
        ap = (idx_reg != '0) && (prv.start + prv.length == blk_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        mark_next = mark_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        op_next = op_reg;
        blk_next = blk_reg;
        len_next = len_reg;
        st_next = st_reg;
        ga_next = ga_reg;
        bb_next = bb_reg;
        done_next = 1'b0;
        shift_next = shift_reg;
        pivot_next = pivot_reg;
        cnt_after_next = cnt_after_reg;
        wr_en = 1'b0;
        wr_idx = ci;
        wr_seg = '{valid: 1'b1, start: cur.start, length: cur.length};
        if (cfg_we && cfg_index == ffca_pkg::CFG_HEAP_BASE)
        begin
            mark_next = cfg_data;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = req.opcode;
                    idx_next = '0;
                    st_next = ffca_pkg::ST_OK;
                    ga_next = '0;
                    bb_next = '0;
                    shift_next = ffca_pkg::CC_HOLD;
                    blk_next = blk33[31:0];
                    len_next = req.header_word;
                    state_next = S_SCAN;
                    if (req.opcode == ffca_pkg::OP_ALLOC)
                    begin
                        if (req.request_bytes == '0)
                        begin
                            st_next = ffca_pkg::ST_ZERO;
                            state_next = S_DONE;
                        end
                        else if (blk33[32])
                        begin
                            st_next = ffca_pkg::ST_TOO_LARGE;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        blk_next = req.payload_address - GR;
                        if (req.payload_address == '0)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_PREP:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (op_reg == ffca_pkg::OP_ALLOC)
                begin
                    if (idx_reg >= count_reg)
                    begin
                        state_next = S_ACT;
                    end
                    else if (blk_reg <= cur.length)
                    begin
                        wr_en = 1'b1;
                        wr_seg.length = newlen;
                        ga_next = cur.start + newlen + GR;
                        bb_next = blk_reg;
                        if (newlen == '0)
                        begin
                            shift_next = ffca_pkg::CC_LEFT;
                            pivot_next = ci;
                            cnt_after_next = count_reg - CW'(1);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                else
                begin
                    if (idx_reg < count_reg && cur.start < blk_reg)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                    else
                    begin
                        state_next = S_ACT;
                    end
                end
            end
            S_ACT:
            begin
                state_next = S_DONE;
                if (op_reg == ffca_pkg::OP_ALLOC)
                begin
                    if (mark_reg > limit_reg || inc33 > {1'b0, diff})
                    begin
                        st_next = ffca_pkg::ST_EXHAUSTED;
                    end
                    else
                    begin
                        ga_next = mark_reg + pad + GR;
                        bb_next = blk_reg;
                        mark_next = mark_reg + inc33[31:0];
                    end
                end
                else
                begin
                    if (ap)
                    begin
                        wr_en = 1'b1;
                        wr_idx = pi;
                        wr_seg.start = prv.start;
                        wr_seg.length = prv.length + len_reg + (an ? cur.length : 32'd0);
                        if (an)
                        begin
                            shift_next = ffca_pkg::CC_LEFT;
                            pivot_next = ci;
                            cnt_after_next = count_reg - CW'(1);
                            state_next = S_SHIFT;
                        end
                    end
                    else if (an)
                    begin
                        wr_en = 1'b1;
                        wr_seg.start = blk_reg;
                        wr_seg.length = len_reg + cur.length;
                    end
                    else if (count_reg >= FULL)
                    begin
                        st_next = ffca_pkg::ST_TABLE_FULL;
                    end
                    else
                    begin
                        shift_next = ffca_pkg::CC_RIGHT;
                        pivot_next = ci;
                        cnt_after_next = count_reg + CW'(1);
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                count_next = cnt_after_reg;
                if (shift_reg == ffca_pkg::CC_RIGHT)
                begin
                    wr_en = 1'b1;
                    wr_idx = pivot_reg;
                    wr_seg.start = blk_reg;
                    wr_seg.length = len_reg;
                end
                shift_next = ffca_pkg::CC_HOLD;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= '0;
            mark_reg <= '0;
            count_reg <= '0;
            done_reg <= 1'b0;
            shift_reg <= ffca_pkg::CC_HOLD;
        end
        else
        begin
            state_reg <= state_next;
            mark_reg <= mark_next;
            count_reg <= count_next;
            done_reg <= done_next;
            shift_reg <= shift_next;
            if (cfg_we && cfg_index == ffca_pkg::CFG_HEAP_LIMIT)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        op_reg <= op_next;
        blk_reg <= blk_next;
        len_reg <= len_next;
        st_reg <= st_next;
        ga_reg <= ga_next;
        bb_reg <= bb_next;
        pivot_reg <= pivot_next;
        cnt_after_reg <= cnt_after_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp.status = st_reg;
    assign rsp.granted_address = done_reg ? ga_reg : 32'd0;
    assign rsp.block_bytes = done_reg ? bb_reg : 32'd0;

endmodule
